// ===== sv/e2c_pkg.sv =====
package e2c_pkg;

  // Field widths
  localparam int EPOCH_W  = 32;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  // Calendar constants
  localparam logic [EPOCH_W-1:0] EPOCH_LIMIT   = 32'd4102444799;
  localparam logic [YEAR_W-1:0]  BASE_YEAR     = 12'd1970;
  localparam logic [EPOCH_W-1:0] DAYS_PER_YEAR = 32'd365;
  localparam logic [EPOCH_W-1:0] SECS_PER_MIN  = 32'd60;
  localparam logic [EPOCH_W-1:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [EPOCH_W-1:0] SECS_PER_DAY  = 32'd86400;

  // Quotient bit counts of the three constant divisions
  localparam int DAYQ_W  = 16;  // days since epoch < 2^16
  localparam int HOURQ_W = 5;   // hour < 24
  localparam int MINQ_W  = 6;   // minute < 60
  localparam int YOFF_W  = 8;   // years since base, at most 129
  localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd11;  // December, zero based
  localparam logic [MONTH_W-1:0] FEB        = 4'd1;

  // Shared subtract/compare unit result
  typedef struct packed {
    logic [EPOCH_W-1:0] diff;
    logic               ge;
  } alu_res_t;

  // Finished conversion
  typedef struct packed {
    logic [YEAR_W-1:0]   cal_year;
    logic [MONTH_W-1:0]  cal_month;
    logic [DAY_W-1:0]    cal_day;
    logic [HOUR_W-1:0]   clock_hour;
    logic [MINUTE_W-1:0] clock_minute;
    logic [SECOND_W-1:0] clock_second;
  } result_t;

  // Days in a month of a common year, month zero based
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mon);
    logic [DAY_W-1:0] len;
    case (mon) inside
      4'd1:                   len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/e2c_if.sv =====
interface e2c_in_if;
  import e2c_pkg::*;
  logic               valid;
  logic               ready;
  logic [EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface e2c_out_if;
  import e2c_pkg::*;
  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   cal_year;
  logic [MONTH_W-1:0]  cal_month;
  logic [DAY_W-1:0]    cal_day;
  logic [HOUR_W-1:0]   clock_hour;
  logic [MINUTE_W-1:0] clock_minute;
  logic [SECOND_W-1:0] clock_second;

  modport source (output valid, output cal_year, output cal_month, output cal_day,
                  output clock_hour, output clock_minute, output clock_second,
                  input ready);
  modport sink   (input valid, input cal_year, input cal_month, input cal_day,
                  input clock_hour, input clock_minute, input clock_second,
                  output ready);
endinterface

// ===== sv/e2c_alu.sv =====
module e2c_alu (
  input  logic [e2c_pkg::EPOCH_W-1:0] a,
  input  logic [e2c_pkg::EPOCH_W-1:0] b,
  output e2c_pkg::alu_res_t           res
);
  import e2c_pkg::*;

  logic borrow;

  // One compare-and-subtract, shared by every step of the sequencer
  assign {borrow, res.diff} = {1'b0, a} - {1'b0, b};
  assign res.ge = ~borrow;

endmodule

// ===== sv/e2c_seq.sv =====
module e2c_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [e2c_pkg::EPOCH_W-1:0] epoch,
  output logic                        idle,
  output logic                        res_valid,
  input  logic                        res_take,
  output e2c_pkg::result_t            res,
  output logic [e2c_pkg::EPOCH_W-1:0] alu_a,
  output logic [e2c_pkg::EPOCH_W-1:0] alu_b,
  input  e2c_pkg::alu_res_t           alu_r
);
  import e2c_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DAY   = 7'b0000010,
    ST_HOUR  = 7'b0000100,
    ST_MIN   = 7'b0001000,
    ST_YEAR  = 7'b0010000,
    ST_MONTH = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t                state, state_next;
  logic [EPOCH_W-1:0]    rem;
  logic [DAYQ_W-1:0]     quo;
  logic [3:0]            k;
  logic [DAYQ_W-1:0]     days;
  logic [HOUR_W-1:0]     hour;
  logic [MINUTE_W-1:0]   minute;
  logic [SECOND_W-1:0]   second;
  logic [YOFF_W-1:0]     yoff;
  logic [MONTH_W-1:0]    mon;
  logic                  leap;

  logic                  leap_cur;
  logic [DAY_W-1:0]      mlen;
  logic [DAYQ_W-1:0]     quo_set;
  logic [EPOCH_W-1:0]    rem_new;
  logic [EPOCH_W-1:0]    t_sat;

  // Year offset 2 mod 4 is a leap year (1972, 1976, ...)
  assign leap_cur = ((yoff[1:0] + 2'd2) == 2'd0);
  assign mlen     = month_len(mon) + {4'd0, leap && (mon == FEB)};
  assign t_sat    = (epoch > EPOCH_LIMIT) ? EPOCH_LIMIT : epoch;

  // Operand select for the shared unit
  always_comb begin
    alu_a = rem;
    case (state)
      ST_DAY:   alu_b = SECS_PER_DAY << k;
      ST_HOUR:  alu_b = SECS_PER_HOUR << k;
      ST_MIN:   alu_b = SECS_PER_MIN << k;
      ST_YEAR:  alu_b = DAYS_PER_YEAR + {31'd0, leap_cur};
      ST_MONTH: alu_b = {27'd0, mlen};
      default:  alu_b = '0;
    endcase
  end

  // Restoring division step: keep the difference and set the quotient bit
  always_comb begin
    quo_set = quo;
    if (alu_r.ge) begin
      quo_set[k] = 1'b1;
    end
    rem_new = alu_r.ge ? alu_r.diff : rem;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_DAY;
      ST_DAY:   if (k == 4'd0) state_next = ST_HOUR;
      ST_HOUR:  if (k == 4'd0) state_next = ST_MIN;
      ST_MIN:   if (k == 4'd0) state_next = ST_YEAR;
      ST_YEAR:  if (!alu_r.ge) state_next = ST_MONTH;
      ST_MONTH: if (mon == LAST_MONTH || !alu_r.ge) state_next = ST_DONE;
      ST_DONE:  if (res_take) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rem <= t_sat;
        quo <= '0;
        k   <= 4'(DAYQ_W - 1);
      end
      ST_DAY: begin
        rem <= rem_new;
        if (k == 4'd0) begin
          days <= quo_set;
          quo  <= '0;
          k    <= 4'(HOURQ_W - 1);
        end else begin
          quo <= quo_set;
          k   <= k - 4'd1;
        end
      end
      ST_HOUR: begin
        rem <= rem_new;
        if (k == 4'd0) begin
          hour <= quo_set[HOUR_W-1:0];
          quo  <= '0;
          k    <= 4'(MINQ_W - 1);
        end else begin
          quo <= quo_set;
          k   <= k - 4'd1;
        end
      end
      ST_MIN: begin
        if (k == 4'd0) begin
          minute <= quo_set[MINUTE_W-1:0];
          second <= rem_new[SECOND_W-1:0];
          rem    <= {{(EPOCH_W-DAYQ_W){1'b0}}, days};
          yoff   <= '0;
        end else begin
          rem <= rem_new;
          quo <= quo_set;
          k   <= k - 4'd1;
        end
      end
      ST_YEAR: begin
        if (alu_r.ge) begin
          rem  <= alu_r.diff;
          yoff <= yoff + 8'd1;
        end else begin
          leap <= leap_cur;
          mon  <= '0;
        end
      end
      ST_MONTH: begin
        if (mon != LAST_MONTH && alu_r.ge) begin
          rem <= alu_r.diff;
          mon <= mon + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  assign res.cal_year     = BASE_YEAR + {{(YEAR_W-YOFF_W){1'b0}}, yoff};
  assign res.cal_month    = mon + 4'd1;
  assign res.cal_day      = rem[DAY_W-1:0] + 5'd1;
  assign res.clock_hour   = hour;
  assign res.clock_minute = minute;
  assign res.clock_second = second;

endmodule

// ===== sv/epoch_to_calendar.sv =====
// Channel   Role    Transaction payload
// in_ch     sink    epoch_seconds [31:0]
// out_ch    source  cal_year, cal_month, cal_day, clock_hour, clock_minute, clock_second
//
// One conversion at a time. Its duration is set by the single compare/subtract
// unit: 27 restoring-division steps, then one step per whole year and per whole
// month, plus one step that ends each of those two searches.
// rst is synchronous and clears the sequencer and the output valid.
// A stalled output holds its result; the next input is taken once the result
// has moved to the output register.
module epoch_to_calendar (
  input  logic      clk,
  input  logic      rst,
  e2c_in_if.sink    in_ch,
  e2c_out_if.source out_ch
);
  import e2c_pkg::*;

  logic               seq_idle;
  logic               res_valid;
  logic               res_take;
  result_t            res;
  result_t            out_q;
  logic               out_valid;
  logic [EPOCH_W-1:0] alu_a;
  logic [EPOCH_W-1:0] alu_b;
  alu_res_t           alu_r;

  e2c_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_r)
  );

  e2c_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (in_ch.valid && in_ch.ready),
    .epoch     (in_ch.epoch_seconds),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_r     (alu_r)
  );

  assign in_ch.ready = seq_idle;

  // Output register
  assign res_take = res_valid && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.cal_year     = out_q.cal_year;
  assign out_ch.cal_month    = out_q.cal_month;
  assign out_ch.cal_day      = out_q.cal_day;
  assign out_ch.clock_hour   = out_q.clock_hour;
  assign out_ch.clock_minute = out_q.clock_minute;
  assign out_ch.clock_second = out_q.clock_second;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a conversion runs");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_q.cal_month >= 4'd1 && out_q.cal_month <= 4'd12 &&
                   out_q.cal_day >= 5'd1 && out_q.cal_year <= 12'd2099))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_q.clock_hour < 5'd24 && out_q.clock_minute < 6'd60 &&
                   out_q.clock_second < 6'd60))
    else $error("time field out of range");

endmodule

// ===== sim/tb_epoch_to_calendar.sv =====
`timescale 1ns / 1ps

module tb_epoch_to_calendar;
  import e2c_pkg::*;

  localparam int          CLK_HALF      = 4;
  localparam int          RESET_CYCLES  = 10;
  localparam int          RANDOM_ITEMS  = 450;
  localparam int          QUIET_TAIL    = 50;    // last transactions sent with no idling
  localparam int          SETTLE_CYCLES = 400;   // well past the worst-case conversion time
  localparam int          MAX_REPORTS   = 10;
  localparam longint      CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned TWO_DAYS      = 2 * 86400;

  // Days per month in a common year, January first
  localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    logic [EPOCH_W-1:0] epoch;
    bit                 drain;  // hold until every outstanding result is back
  } epoch_item_t;

  typedef struct {
    logic [EPOCH_W-1:0] epoch;
    result_t            want;
  } calendar_expect_t;

  logic clk = 1'b0;
  logic rst;

  e2c_in_if  in_ch ();
  e2c_out_if out_ch ();

  epoch_to_calendar dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  epoch_item_t      epoch_q[$];
  calendar_expect_t calendar_q[$];

  int     error_count    = 0;
  int     sent_count     = 0;
  int     saturated_sent = 0;
  int     result_count   = 0;
  int     leap_day_count = 0;
  int     min_year       = 4095;
  int     max_year       = 0;
  longint cycle_count    = 0;

  // Calendar conversion of a seconds count, four-year leap rule valid to 2099
  function automatic result_t convert_epoch(input logic [EPOCH_W-1:0] secs);
    result_t          r;
    logic [EPOCH_W-1:0] t;
    int unsigned      days;
    int unsigned      yoff;
    logic [MONTH_W-1:0] mon;
    bit               leap;
    t = (secs > EPOCH_LIMIT) ? EPOCH_LIMIT : secs;
    r.clock_second = SECOND_W'(t % SECS_PER_MIN);
    r.clock_minute = MINUTE_W'((t / SECS_PER_MIN) % 60);
    r.clock_hour   = HOUR_W'((t / SECS_PER_HOUR) % 24);
    days = t / SECS_PER_DAY;
    // strip whole years; 1972 is the first leap year
    yoff = 0;
    leap = 1'b0;
    while (days >= DAYS_PER_YEAR + leap) begin
      days -= DAYS_PER_YEAR + leap;
      yoff++;
      leap = ((yoff + 2) % 4) == 0;
    end
    // strip whole months; December takes whatever is left
    mon = '0;
    while (mon < LAST_MONTH && days >= DAYS_IN_MONTH[mon] + (leap && mon == FEB)) begin
      days -= DAYS_IN_MONTH[mon] + (leap && mon == FEB);
      mon++;
    end
    r.cal_year  = YEAR_W'(BASE_YEAR + yoff);
    r.cal_month = MONTH_W'(mon + 1);
    r.cal_day   = DAY_W'(days + 1);
    return r;
  endfunction

  // Seconds count at midnight starting the given date
  function automatic logic [EPOCH_W-1:0] midnight_of(input int unsigned year,
                                                     input int unsigned month,
                                                     input int unsigned day);
    longint unsigned days;
    days = day - 1;
    for (int unsigned y = BASE_YEAR; y < year; y++) days += (y % 4 == 0) ? 366 : 365;
    for (int unsigned m = 1; m < month; m++)
      days += DAYS_IN_MONTH[m-1] + ((m == 2 && year % 4 == 0) ? 1 : 0);
    return EPOCH_W'(days * 86400);
  endfunction

  task automatic queue_epoch(input logic [EPOCH_W-1:0] epoch, input bit drain = 1'b0);
    epoch_item_t item;
    item.epoch = epoch;
    item.drain = drain;
    epoch_q.push_back(item);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got, input logic [EPOCH_W-1:0] epoch);
    if (want != got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("ERROR: epoch %0d %s expected %0d got %0d", epoch, name, want, got);
    end
  endtask

  // Stimulus, reset and end of run
  initial begin
    logic [EPOCH_W-1:0] base;
    int unsigned        pick;
    int unsigned        span;

    rst                  = 1'b1;
    in_ch.valid          = 1'b0;
    in_ch.epoch_seconds  = '0;
    out_ch.ready         = 1'b0;

    // time-of-day and field extremes
    queue_epoch(32'd0);
    queue_epoch(32'd59);
    queue_epoch(32'd3599);
    queue_epoch(32'd86399);
    queue_epoch(32'd86400);
    queue_epoch(midnight_of(1970, 3, 1));
    queue_epoch(midnight_of(1970, 7, 31) + 45296);
    // leap years: first one, a century year, a late one
    queue_epoch(midnight_of(1972, 2, 29) + 43210);
    queue_epoch(midnight_of(1972, 3, 1) - 1);
    queue_epoch(midnight_of(1972, 12, 31) + 86399);
    queue_epoch(midnight_of(1973, 1, 1));
    queue_epoch(midnight_of(2000, 2, 29));
    queue_epoch(midnight_of(2096, 2, 29) + 86399);
    queue_epoch(midnight_of(2099, 3, 1) - 1);
    // bit patterns and the top of the range
    queue_epoch(32'h7FFF_FFFF);
    queue_epoch(32'h8000_0000);
    queue_epoch(32'h5555_5555);
    queue_epoch(32'hAAAA_AAAA);
    queue_epoch(midnight_of(2099, 12, 31));
    queue_epoch(EPOCH_LIMIT - 1);
    queue_epoch(EPOCH_LIMIT);
    // saturation past the end of 2099
    queue_epoch(EPOCH_LIMIT + 1);
    queue_epoch(32'hFFFF_FFFF);

    // random part: uniform, month/year edges, over the limit, raw 32-bit
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        base = $urandom_range(0, EPOCH_LIMIT);
      end else if (pick < 75) begin
        base = midnight_of($urandom_range(BASE_YEAR, 2099), $urandom_range(1, 12), 1);
        span = $urandom_range(0, 2 * TWO_DAYS);
        base = (base >= TWO_DAYS) ? base - TWO_DAYS + span : base + span;
      end else if (pick < 85) begin
        base = $urandom_range(EPOCH_LIMIT + 1, 32'hFFFF_FFFF);
      end else begin
        base = $urandom;
      end
      queue_epoch(base, i == 0 || i == 150 || i == 300);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (epoch_q.size() != 0 || in_ch.valid || calendar_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Converted %0d timestamps (%0d past the 2099 limit, %0d landing on Feb 29),",
             sent_count, saturated_sent, leap_day_count);
    $display("results spanning years %0d to %0d under random input gaps and output stalls.",
             min_year, max_year);
    if (error_count == 0) begin
      $display("tb_epoch_to_calendar OK");
    end else begin
      $display("tb_epoch_to_calendar NOT OK");
    end
    $finish;
  end

  // Driver: presents queued timestamps with idle bursts
  int unsigned gap_left = 0;
  int unsigned gap_pct  = 20;

  always @(posedge clk) begin
    logic        next_valid;
    epoch_item_t item;
    if (rst) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      next_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        calendar_q.push_back('{epoch: in_ch.epoch_seconds,
                               want: convert_epoch(in_ch.epoch_seconds)});
        sent_count++;
        if (in_ch.epoch_seconds > EPOCH_LIMIT) saturated_sent++;
        next_valid = 1'b0;
        // change idling density every 40 transactions, including none at all
        if (sent_count % 40 == 0) begin
          case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 20;
            default: gap_pct = 60;
          endcase
        end
        if (epoch_q.size() >= QUIET_TAIL && $urandom_range(0, 99) < gap_pct)
          gap_left = $urandom_range(1, 11);
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (epoch_q.size() != 0 && !(epoch_q[0].drain && calendar_q.size() != 0)) begin
          item = epoch_q.pop_front();
          in_ch.epoch_seconds <= item.epoch;
          next_valid = 1'b1;
        end
      end
      in_ch.valid <= next_valid;
    end
  end

  // Monitor: checks each result transaction against the oldest prediction
  int unsigned stall_left = 0;
  int unsigned stall_pct  = 5;

  always @(posedge clk) begin
    result_t          got;
    calendar_expect_t exp;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{cal_year: out_ch.cal_year, cal_month: out_ch.cal_month,
                cal_day: out_ch.cal_day, clock_hour: out_ch.clock_hour,
                clock_minute: out_ch.clock_minute, clock_second: out_ch.clock_second};
        result_count++;
        if (calendar_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("ERROR: unexpected result %0d-%0d-%0d %0d:%0d:%0d", got.cal_year,
                     got.cal_month, got.cal_day, got.clock_hour, got.clock_minute,
                     got.clock_second);
        end else begin
          exp = calendar_q.pop_front();
          check_field("cal_year",     exp.want.cal_year,     got.cal_year,     exp.epoch);
          check_field("cal_month",    exp.want.cal_month,    got.cal_month,    exp.epoch);
          check_field("cal_day",      exp.want.cal_day,      got.cal_day,      exp.epoch);
          check_field("clock_hour",   exp.want.clock_hour,   got.clock_hour,   exp.epoch);
          check_field("clock_minute", exp.want.clock_minute, got.clock_minute, exp.epoch);
          check_field("clock_second", exp.want.clock_second, got.clock_second, exp.epoch);
        end
        if (got.cal_year < min_year) min_year = got.cal_year;
        if (got.cal_year > max_year) max_year = got.cal_year;
        if (got.cal_month == 2 && got.cal_day == 29) leap_day_count++;
        if (result_count % 40 == 0) begin
          case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 3;
            default: stall_pct = 12;
          endcase
        end
      end
      // stalls may start on any cycle so they hit every phase of a conversion
      if (stall_left == 0 && epoch_q.size() >= QUIET_TAIL && $urandom_range(0, 99) < stall_pct)
        stall_left = $urandom_range(1, 11);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               calendar_q.size());
      $display("tb_epoch_to_calendar NOT OK");
      $finish;
    end
  end

endmodule
